[src/rdu_pkg.sv]
// ----------------------------------------------------------------------------
// rdu_pkg
// Shared widths, payload types and rounding helper for the refraction
// direction unit.
// ----------------------------------------------------------------------------
package rdu_pkg;

   localparam int FRAC_BITS = 14;

   function automatic int max_int(input int a, input int b);
      return (a > b) ? a : b;
   endfunction

   // widths of the vector datapath, derived from the fraction bits
   localparam int DOT_W  = max_int(35 - FRAC_BITS, 2);
   localparam int RDR_W  = max_int(34 - FRAC_BITS, 2);
   localparam int RDOT_W = DOT_W + 17;
   localparam int K_W    = max_int(RDOT_W + 2 - FRAC_BITS, 17) + 1;
   localparam int KN_W   = K_W + 16;
   localparam int T_W    = max_int(KN_W + 1 - FRAC_BITS, RDR_W) + 1;

   // block scaled magnitudes and length
   localparam int MAG_W  = 24;
   localparam int POS_W  = $clog2(max_int(T_W, MAG_W));
   localparam int SQ_W   = 2 * MAG_W;
   localparam int LEN_W  = SQ_W + 2;
   localparam int ROOT_W = LEN_W / 2;

   // divider
   localparam int Q_W    = FRAC_BITS + 1;
   localparam int NUM_W  = ROOT_W + Q_W;

   localparam int VEC_STAGES   = 6;
   localparam int SCALE_STAGES = 5;
   localparam int DIV_STAGES   = Q_W + 2;

   typedef logic signed [DOT_W-1:0]  dot_type;
   typedef logic signed [RDR_W-1:0]  rdr_type;
   typedef logic signed [RDOT_W-1:0] rdot_type;
   typedef logic signed [K_W-1:0]    k_type;
   typedef logic signed [KN_W-1:0]   kn_type;
   typedef logic signed [T_W-1:0]    t_type;
   typedef logic [T_W-1:0]           abs_type;
   typedef logic [POS_W-1:0]         pos_type;
   typedef logic [MAG_W-1:0]         mag_type;
   typedef logic [SQ_W-1:0]          sq_type;
   typedef logic [LEN_W-1:0]         len_type;
   typedef logic [LEN_W:0]           trial_type;
   typedef logic [ROOT_W-1:0]        root_type;
   typedef logic [NUM_W-1:0]         num_type;
   typedef logic [Q_W-1:0]           q_type;

   typedef struct packed {
      logic signed [15:0] normal_x;
      logic signed [15:0] normal_y;
      logic signed [15:0] normal_z;
      logic signed [15:0] dir_x;
      logic signed [15:0] dir_y;
      logic signed [15:0] dir_z;
      logic [15:0]        index_ratio;
      logic [15:0]        root_term;
   } req_type;

   typedef struct packed {
      logic signed [15:0] out_x;
      logic signed [15:0] out_y;
      logic signed [15:0] out_z;
      logic               degenerate;
   } rsp_type;

   typedef struct packed {
      t_type t_x;
      t_type t_y;
      t_type t_z;
   } vec_type;

   typedef struct packed {
      mag_type m_x;
      mag_type m_y;
      mag_type m_z;
      logic    neg_x;
      logic    neg_y;
      logic    neg_z;
      logic    zero;
   } scaled_type;

   // round to nearest, half toward +inf, dropping the fraction bits
   function automatic logic signed [63:0] rnd(input logic signed [63:0] x);
      logic signed [63:0] half;
      half = 64'sd1 <<< (FRAC_BITS - 1);
      return (x + half) >>> FRAC_BITS;
   endfunction

endpackage

[src/rdu_channel_if.sv]
// ----------------------------------------------------------------------------
// rdu_channel_if
// Valid/ready channels carrying request and response transactions.
// ----------------------------------------------------------------------------
interface rdu_req_if;
   logic             valid;
   logic             ready;
   rdu_pkg::req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface rdu_rsp_if;
   logic             valid;
   logic             ready;
   rdu_pkg::rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

[src/rdu_vector.sv]
// ----------------------------------------------------------------------------
// rdu_vector
// Six stage pipeline forming t = r*D + (-r*(N.D) - s)*N.
// ----------------------------------------------------------------------------
module rdu_vector (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  logic                in_valid,
   input  rdu_pkg::req_type    in_data,
   output logic                out_valid,
   output rdu_pkg::vec_type    out_data
);

   logic signed [15:0] n_in [3];
   logic signed [15:0] d_in [3];

   logic [rdu_pkg::VEC_STAGES-1:0] v_ff;

   logic signed [31:0] nd1_ff [3];
   logic signed [32:0] rd1_ff [3];
   logic signed [15:0] n1_ff [3];
   logic signed [15:0] n2_ff [3];
   logic signed [15:0] n3_ff [3];
   logic signed [15:0] n4_ff [3];
   logic [15:0]        r1_ff;
   logic [15:0]        r2_ff;
   logic [15:0]        s1_ff;
   logic [15:0]        s2_ff;
   logic [15:0]        s3_ff;
   rdu_pkg::dot_type   dot2_ff;
   rdu_pkg::rdr_type   rdr2_ff [3];
   rdu_pkg::rdr_type   rdr3_ff [3];
   rdu_pkg::rdr_type   rdr4_ff [3];
   rdu_pkg::rdr_type   rdr5_ff [3];
   rdu_pkg::rdot_type  rdot3_ff;
   rdu_pkg::k_type     k4_ff;
   rdu_pkg::kn_type    kn5_ff [3];
   rdu_pkg::t_type     t6_ff [3];
   logic signed [63:0] dot_sum;

   assign n_in[0] = in_data.normal_x;
   assign n_in[1] = in_data.normal_y;
   assign n_in[2] = in_data.normal_z;
   assign d_in[0] = in_data.dir_x;
   assign d_in[1] = in_data.dir_y;
   assign d_in[2] = in_data.dir_z;

   assign dot_sum = 64'(nd1_ff[0]) + 64'(nd1_ff[1]) + 64'(nd1_ff[2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (advance) begin
         v_ff <= {v_ff[rdu_pkg::VEC_STAGES-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         // products of the inputs
         for (int i = 0; i < 3; i++) begin
            nd1_ff[i] <= 32'(n_in[i]) * 32'(d_in[i]);
            rd1_ff[i] <= 33'($signed({1'b0, in_data.index_ratio})) * 33'(d_in[i]);
            n1_ff[i]  <= n_in[i];
         end
         r1_ff <= in_data.index_ratio;
         s1_ff <= in_data.root_term;

         // dot product and rounded r*D
         dot2_ff <= rdu_pkg::dot_type'(rdu_pkg::rnd(dot_sum));
         for (int i = 0; i < 3; i++) begin
            rdr2_ff[i] <= rdu_pkg::rdr_type'(rdu_pkg::rnd(64'(rd1_ff[i])));
            n2_ff[i]   <= n1_ff[i];
         end
         r2_ff <= r1_ff;
         s2_ff <= s1_ff;

         // r*dot
         rdot3_ff <= rdu_pkg::rdot_type'($signed({1'b0, r2_ff})) * rdu_pkg::rdot_type'(dot2_ff);
         rdr3_ff  <= rdr2_ff;
         n3_ff    <= n2_ff;
         s3_ff    <= s2_ff;

         // k = -rnd(r*dot) - s
         k4_ff   <= rdu_pkg::k_type'(-rdu_pkg::rnd(64'(rdot3_ff))
                                      - 64'($signed({1'b0, s3_ff})));
         rdr4_ff <= rdr3_ff;
         n4_ff   <= n3_ff;

         // k*N
         for (int i = 0; i < 3; i++) begin
            kn5_ff[i] <= rdu_pkg::kn_type'(k4_ff) * rdu_pkg::kn_type'(n4_ff[i]);
         end
         rdr5_ff <= rdr4_ff;

         // t = rnd(r*D) + rnd(k*N)
         for (int i = 0; i < 3; i++) begin
            t6_ff[i] <= rdu_pkg::t_type'(rdu_pkg::rnd(64'(kn5_ff[i])) + 64'(rdr5_ff[i]));
         end
      end
   end

   assign out_valid     = v_ff[rdu_pkg::VEC_STAGES-1];
   assign out_data.t_x  = t6_ff[0];
   assign out_data.t_y  = t6_ff[1];
   assign out_data.t_z  = t6_ff[2];

endmodule

[src/rdu_scale.sv]
// ----------------------------------------------------------------------------
// rdu_scale
// Magnitudes, common block scaling and squared length, five stages.
// ----------------------------------------------------------------------------
module rdu_scale (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  logic                in_valid,
   input  rdu_pkg::vec_type    in_data,
   output logic                out_valid,
   output rdu_pkg::scaled_type out_data,
   output rdu_pkg::len_type    out_len
);

   logic [rdu_pkg::SCALE_STAGES-1:0] v_ff;

   rdu_pkg::t_type      t_in [3];
   rdu_pkg::abs_type    m1_ff [3];
   rdu_pkg::abs_type    m2_ff [3];
   logic                neg1_ff [3];
   logic                neg2_ff [3];
   logic                zero1_ff;
   logic                zero2_ff;
   rdu_pkg::abs_type    or_all;
   rdu_pkg::pos_type    pos_in;
   rdu_pkg::pos_type    pos2_ff;
   rdu_pkg::pos_type    top_pos;
   rdu_pkg::mag_type    ms_in [3];
   rdu_pkg::scaled_type sc3_ff;
   rdu_pkg::scaled_type sc4_ff;
   rdu_pkg::scaled_type sc5_ff;
   rdu_pkg::sq_type     sq4_ff [3];
   rdu_pkg::len_type    len5_ff;

   assign t_in[0] = in_data.t_x;
   assign t_in[1] = in_data.t_y;
   assign t_in[2] = in_data.t_z;
   assign top_pos = rdu_pkg::pos_type'(rdu_pkg::MAG_W - 1);

   // highest set bit over all three magnitudes sets the common shift
   always_comb begin
      or_all = m1_ff[0] | m1_ff[1] | m1_ff[2];
      pos_in = '0;
      for (int b = 0; b < rdu_pkg::T_W; b++) begin
         if (or_all[b]) begin
            pos_in = rdu_pkg::pos_type'(b);
         end
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (pos2_ff >= top_pos) begin
            ms_in[i] = rdu_pkg::mag_type'(m2_ff[i] >> (pos2_ff - top_pos));
         end else begin
            ms_in[i] = rdu_pkg::mag_type'(m2_ff[i]) << (top_pos - pos2_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (advance) begin
         v_ff <= {v_ff[rdu_pkg::SCALE_STAGES-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < 3; i++) begin
            neg1_ff[i] <= t_in[i][rdu_pkg::T_W-1];
            m1_ff[i]   <= t_in[i][rdu_pkg::T_W-1] ? rdu_pkg::abs_type'(-t_in[i])
                                                  : rdu_pkg::abs_type'(t_in[i]);
         end
         zero1_ff <= (in_data.t_x == '0) && (in_data.t_y == '0) && (in_data.t_z == '0);

         pos2_ff  <= pos_in;
         m2_ff    <= m1_ff;
         neg2_ff  <= neg1_ff;
         zero2_ff <= zero1_ff;

         sc3_ff.m_x   <= ms_in[0];
         sc3_ff.m_y   <= ms_in[1];
         sc3_ff.m_z   <= ms_in[2];
         sc3_ff.neg_x <= neg2_ff[0];
         sc3_ff.neg_y <= neg2_ff[1];
         sc3_ff.neg_z <= neg2_ff[2];
         sc3_ff.zero  <= zero2_ff;

         sq4_ff[0] <= rdu_pkg::sq_type'(sc3_ff.m_x) * rdu_pkg::sq_type'(sc3_ff.m_x);
         sq4_ff[1] <= rdu_pkg::sq_type'(sc3_ff.m_y) * rdu_pkg::sq_type'(sc3_ff.m_y);
         sq4_ff[2] <= rdu_pkg::sq_type'(sc3_ff.m_z) * rdu_pkg::sq_type'(sc3_ff.m_z);
         sc4_ff    <= sc3_ff;

         len5_ff <= rdu_pkg::len_type'(sq4_ff[0]) + rdu_pkg::len_type'(sq4_ff[1])
                  + rdu_pkg::len_type'(sq4_ff[2]);
         sc5_ff  <= sc4_ff;
      end
   end

   assign out_valid = v_ff[rdu_pkg::SCALE_STAGES-1];
   assign out_data  = sc5_ff;
   assign out_len   = len5_ff;

endmodule

[src/rdu_sqrt.sv]
// ----------------------------------------------------------------------------
// rdu_sqrt
// Integer square root of the squared length, one result bit per stage.
// ----------------------------------------------------------------------------
module rdu_sqrt (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  logic                in_valid,
   input  rdu_pkg::scaled_type in_data,
   input  rdu_pkg::len_type    in_len,
   output logic                out_valid,
   output rdu_pkg::scaled_type out_data,
   output rdu_pkg::root_type   out_root
);

   logic [rdu_pkg::ROOT_W-1:0] v_ff;
   rdu_pkg::len_type           rem_ff  [rdu_pkg::ROOT_W];
   rdu_pkg::root_type          root_ff [rdu_pkg::ROOT_W];
   rdu_pkg::scaled_type        sc_ff   [rdu_pkg::ROOT_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (advance) begin
         v_ff <= {v_ff[rdu_pkg::ROOT_W-2:0], in_valid};
      end
   end

   for (genvar k = 0; k < rdu_pkg::ROOT_W; k++) begin : g_step
      localparam int B = rdu_pkg::ROOT_W - 1 - k;

      rdu_pkg::len_type    rem_src;
      rdu_pkg::root_type   root_src;
      rdu_pkg::scaled_type sc_src;
      rdu_pkg::trial_type  trial;
      logic                take;

      if (k == 0) begin : g_first
         assign rem_src  = in_len;
         assign root_src = '0;
         assign sc_src   = in_data;
      end else begin : g_next
         assign rem_src  = rem_ff[k-1];
         assign root_src = root_ff[k-1];
         assign sc_src   = sc_ff[k-1];
      end

      // (root + 2^B)^2 - root^2
      assign trial = (rdu_pkg::trial_type'(root_src) << (B + 1))
                   + (rdu_pkg::trial_type'(1) << (2 * B));
      assign take  = {1'b0, rem_src} >= trial;

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[k]  <= take ? rem_src - rdu_pkg::len_type'(trial) : rem_src;
            root_ff[k] <= take ? root_src | (rdu_pkg::root_type'(1) << B) : root_src;
            sc_ff[k]   <= sc_src;
         end
      end
   end

   assign out_valid = v_ff[rdu_pkg::ROOT_W-1];
   assign out_data  = sc_ff[rdu_pkg::ROOT_W-1];
   assign out_root  = root_ff[rdu_pkg::ROOT_W-1];

endmodule

[src/rdu_div.sv]
// ----------------------------------------------------------------------------
// rdu_div
// Rounded division of each magnitude by the length, one quotient bit per
// stage, then sign, saturation and the response register.
// ----------------------------------------------------------------------------
module rdu_div (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  logic                in_valid,
   input  rdu_pkg::scaled_type in_data,
   input  rdu_pkg::root_type   in_root,
   output logic                out_valid,
   output rdu_pkg::rsp_type    out_data
);

   logic [rdu_pkg::DIV_STAGES-1:0] v_ff;

   rdu_pkg::num_type    num0_ff [3];
   rdu_pkg::root_type   len0_ff;
   rdu_pkg::scaled_type sc0_ff;

   rdu_pkg::num_type    rem_ff [rdu_pkg::Q_W][3];
   rdu_pkg::q_type      q_ff   [rdu_pkg::Q_W][3];
   rdu_pkg::root_type   len_ff [rdu_pkg::Q_W];
   rdu_pkg::scaled_type sc_ff  [rdu_pkg::Q_W];

   rdu_pkg::rsp_type    rsp_in;
   rdu_pkg::rsp_type    rsp_ff;
   rdu_pkg::scaled_type sc_last;

   function automatic logic [15:0] finish(input rdu_pkg::q_type q, input logic neg);
      logic [31:0] qw;
      qw = 32'(q);
      if (neg) begin
         return (qw > 32'd32768) ? 16'h8000 : 16'(-qw);
      end else begin
         return (qw > 32'd32767) ? 16'h7fff : 16'(qw);
      end
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (advance) begin
         v_ff <= {v_ff[rdu_pkg::DIV_STAGES-2:0], in_valid};
      end
   end

   // numerator m * 2^F + floor(L/2)
   always_ff @(posedge clock) begin
      if (advance) begin
         num0_ff[0] <= (rdu_pkg::num_type'(in_data.m_x) << rdu_pkg::FRAC_BITS)
                     + rdu_pkg::num_type'(in_root >> 1);
         num0_ff[1] <= (rdu_pkg::num_type'(in_data.m_y) << rdu_pkg::FRAC_BITS)
                     + rdu_pkg::num_type'(in_root >> 1);
         num0_ff[2] <= (rdu_pkg::num_type'(in_data.m_z) << rdu_pkg::FRAC_BITS)
                     + rdu_pkg::num_type'(in_root >> 1);
         len0_ff    <= in_root;
         sc0_ff     <= in_data;
      end
   end

   for (genvar k = 0; k < rdu_pkg::Q_W; k++) begin : g_step
      localparam int B = rdu_pkg::Q_W - 1 - k;

      rdu_pkg::num_type    rem_src [3];
      rdu_pkg::q_type      q_src [3];
      rdu_pkg::root_type   len_src;
      rdu_pkg::scaled_type sc_src;
      rdu_pkg::num_type    sub;
      logic                take [3];

      if (k == 0) begin : g_first
         assign rem_src = num0_ff;
         assign q_src   = '{default: '0};
         assign len_src = len0_ff;
         assign sc_src  = sc0_ff;
      end else begin : g_next
         assign rem_src = rem_ff[k-1];
         assign q_src   = q_ff[k-1];
         assign len_src = len_ff[k-1];
         assign sc_src  = sc_ff[k-1];
      end

      assign sub = rdu_pkg::num_type'(len_src) << B;

      always_comb begin
         for (int i = 0; i < 3; i++) begin
            take[i] = rem_src[i] >= sub;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            for (int i = 0; i < 3; i++) begin
               rem_ff[k][i] <= take[i] ? rem_src[i] - sub : rem_src[i];
               q_ff[k][i]   <= take[i] ? q_src[i] | (rdu_pkg::q_type'(1) << B) : q_src[i];
            end
            len_ff[k] <= len_src;
            sc_ff[k]  <= sc_src;
         end
      end
   end

   assign sc_last = sc_ff[rdu_pkg::Q_W-1];

   // zero vector gives zero outputs and the degenerate flag
   always_comb begin
      rsp_in.degenerate = sc_last.zero;
      if (sc_last.zero) begin
         rsp_in.out_x = '0;
         rsp_in.out_y = '0;
         rsp_in.out_z = '0;
      end else begin
         rsp_in.out_x = $signed(finish(q_ff[rdu_pkg::Q_W-1][0], sc_last.neg_x));
         rsp_in.out_y = $signed(finish(q_ff[rdu_pkg::Q_W-1][1], sc_last.neg_y));
         rsp_in.out_z = $signed(finish(q_ff[rdu_pkg::Q_W-1][2], sc_last.neg_z));
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign out_valid = v_ff[rdu_pkg::DIV_STAGES-1];
   assign out_data  = rsp_ff;

endmodule

[src/refraction_direction_unit.sv]
// ----------------------------------------------------------------------------
// refraction_direction_unit
// Snell's law refracted direction in signed Q2.14, normalized to unit length.
// ----------------------------------------------------------------------------
// usage
//   req_chan carries one ray hit per transaction: normal, incoming direction,
//   index ratio and the root term computed upstream. rsp_chan returns the
//   unit refracted direction and a degenerate flag for a zero vector.
//   both channels are valid/ready; a transaction moves when both are high.
// throughput and pipeline depth
//   one transaction per cycle sustained unless the pipeline stalls. the depth
//   is dominated by the bit-per-stage square root (25 stages) and the
//   bit-per-stage divider (FRAC_BITS + 1 stages).
// reset
//   synchronous, active high; clears every stage valid bit, nothing in flight
// stall
//   the whole pipeline holds while a response waits and rsp_chan.ready is
//   low; req_chan.ready follows the same hold, so nothing is lost or doubled.
//   with an empty response register the pipe keeps taking requests.
// ----------------------------------------------------------------------------
module refraction_direction_unit (
   input  logic      clock,
   input  logic      reset,
   rdu_req_if.sink   req_chan,
   rdu_rsp_if.source rsp_chan
);

   // pipeline moves when the response register is free or being drained
   logic advance;

   logic                vec_valid;
   rdu_pkg::vec_type    vec_data;
   logic                scl_valid;
   rdu_pkg::scaled_type scl_data;
   rdu_pkg::len_type    scl_len;
   logic                sqr_valid;
   rdu_pkg::scaled_type sqr_data;
   rdu_pkg::root_type   sqr_root;
   logic                rsp_valid;
   rdu_pkg::rsp_type    rsp_data;

   assign advance        = !rsp_valid || rsp_chan.ready;
   assign req_chan.ready = advance;

   // t = r*D + (-r*(N.D) - s)*N
   rdu_vector u_vector (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_chan.valid),
      .in_data   (req_chan.payload),
      .out_valid (vec_valid),
      .out_data  (vec_data)
   );

   // magnitudes, block scaling of the largest into [2^23, 2^24), squared length
   rdu_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (vec_valid),
      .in_data   (vec_data),
      .out_valid (scl_valid),
      .out_data  (scl_data),
      .out_len   (scl_len)
   );

   // floor of the square root of the squared length
   rdu_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (scl_valid),
      .in_data   (scl_data),
      .in_len    (scl_len),
      .out_valid (sqr_valid),
      .out_data  (sqr_data),
      .out_root  (sqr_root)
   );

   // rounded division, sign, saturation, response register
   rdu_div u_div (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (sqr_valid),
      .in_data   (sqr_data),
      .in_root   (sqr_root),
      .out_valid (rsp_valid),
      .out_data  (rsp_data)
   );

   assign rsp_chan.valid   = rsp_valid;
   assign rsp_chan.payload = rsp_data;

endmodule

[src/rdu_checker.sv]
// ----------------------------------------------------------------------------
// rdu_checker
// Port level checks of the refraction direction unit, bound to the top.
// ----------------------------------------------------------------------------
module rdu_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input rdu_pkg::rsp_type rsp_payload
);

   // a stalled response holds
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("response changed while stalled");

   // degenerate transactions carry a zero vector
   a_degenerate_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.degenerate |->
         rsp_payload.out_x == '0 && rsp_payload.out_y == '0 && rsp_payload.out_z == '0)
      else $error("degenerate response with nonzero vector");

   // a normalized direction is never the zero vector
   a_unit_nonzero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.degenerate |->
         !(rsp_payload.out_x == '0 && rsp_payload.out_y == '0 && rsp_payload.out_z == '0))
      else $error("normalized response is zero");

   // an empty response register never blocks requests
   a_ready_when_empty : assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request blocked with empty response register");

   // nothing in flight after reset
   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind refraction_direction_unit rdu_checker u_rdu_checker (
   .clock       (clock),
   .reset       (reset),
   .req_ready   (req_chan.ready),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .rsp_payload (rsp_chan.payload)
);
